// ----- design/u8u16_pkg.sv -----
package u8u16_pkg;

  localparam int unsigned MAX_STRING_BYTES = 65535;
  localparam int unsigned BytesLimit =
      (MAX_STRING_BYTES < 65535) ? MAX_STRING_BYTES : 65535;
  localparam logic [15:0] BYTES_LIM = 16'(BytesLimit);

  localparam logic [15:0] CAP_RESET = 16'hFFFF;
  localparam logic [15:0] REPLACE_UNIT = 16'h003F;

  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG = 8'hE0;

  typedef enum logic {
    CFG_ALLOW_INVALID = 1'b0,
    CFG_DEST_CAPACITY = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
    logic        status;
    logic        saw_invalid;
    logic [15:0] bytes_used;
  } res_t;

  typedef struct packed {
    res_t [2:0] item;
    logic [1:0] count;
  } batch_t;

  function automatic res_t mk_res(logic [15:0] unit, logic last, logic st, logic inv,
                                  logic [15:0] cnt);
    res_t r;
    r.code_unit = unit;
    r.last_unit = last;
    r.status = st;
    r.saw_invalid = inv;
    r.bytes_used = cnt;
    return r;
  endfunction

  function automatic logic [15:0] sat_add(logic [15:0] a, logic [1:0] k);
    logic [16:0] sum;
    sum = {1'b0, a} + {15'b0, k};
    if (sum > {1'b0, BYTES_LIM}) begin
      return BYTES_LIM;
    end
    return sum[15:0];
  endfunction

  function automatic logic cap_hit(logic [15:0] uw, logic [15:0] cap);
    return ({1'b0, uw} + 17'd1) >= {1'b0, cap};
  endfunction

endpackage

// ----- design/utf8_to_utf16_decoder_core.sv -----
// channel | direction | payload
// in      | sink      | in_byte_i, end_of_string_i
// out     | source    | code_unit_o, last_unit_o, status_o, saw_invalid_o, bytes_used_o
// cfg     | sink      | cfg_idx_i, cfg_data_i (write only)
//
// one byte per cycle unless stalled: input register, combinational decode, result buffer
// a byte that yields two or three units holds the input until the result buffer drains them
// an accepted byte passes the input register and the result buffer before its first unit appears
// reset clears the control state; held bytes and buffered payload are not reset
// out stall backs up into the input stall while the result buffer still holds unpopped results
module utf8_to_utf16_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_string_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] code_unit_o,
  output logic        last_unit_o,
  output logic        status_o,
  output logic        saw_invalid_o,
  output logic [15:0] bytes_used_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import u8u16_pkg::*;

  logic        allow_q;
  logic [15:0] cap_q;
  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_eos_q;
  logic        free;
  logic        fire;
  logic        in_acc;
  batch_t      batch;
  res_t        res;

  assign fire = in_vld_q && free;
  assign in_stall_o = in_vld_q && !fire;
  assign in_acc = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_q <= 1'b0;
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ALLOW_INVALID: allow_q <= cfg_data_i[0];
        CFG_DEST_CAPACITY: cap_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_acc || (in_vld_q && !fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= in_byte_i;
      in_eos_q <= end_of_string_i;
    end
  end

  u8u16_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .byte_i  (in_byte_q),
    .eos_i   (in_eos_q),
    .allow_i (allow_q),
    .cap_i   (cap_q),
    .batch_o (batch)
  );

  u8u16_res_buf u_res_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .batch_i     (batch),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res),
    .free_o      (free)
  );

  assign code_unit_o = res.code_unit;
  assign last_unit_o = res.last_unit;
  assign status_o = res.status;
  assign saw_invalid_o = res.saw_invalid;
  assign bytes_used_o = res.bytes_used;

endmodule

// ----- design/u8u16_decode.sv -----
module u8u16_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        byte_i,
  input  logic              eos_i,
  input  logic              allow_i,
  input  logic [15:0]       cap_i,
  output u8u16_pkg::batch_t batch_o
);
  import u8u16_pkg::*;

  logic [7:0]  pend_q [2];
  logic [7:0]  pend_d [2];
  logic [1:0]  pcnt_q, pcnt_d;
  logic [15:0] uw_q, uw_d;
  logic [15:0] bc_q, bc_d;
  logic        fin_q, fin_d;
  logic        inv_q, inv_d;

  logic [7:0]  byte_buf [4];
  logic [1:0]  len;
  logic [1:0]  idx;
  logic [1:0]  nres;
  logic        done;
  logic        stop;
  logic [15:0] uw;
  logic [15:0] bc;
  logic        inv;
  res_t [2:0]  items;
  logic [7:0]  cur, nx1, nx2;
  logic        two, three;
  logic        is_emit, is_fin, fin_st;
  logic [15:0] unit;
  logic [1:0]  used;

  // assemble held bytes and the new beat
  always_comb begin
    byte_buf[0] = '0;
    byte_buf[1] = '0;
    byte_buf[2] = '0;
    byte_buf[3] = '0;
    case (pcnt_q)
      2'd0: begin
        byte_buf[0] = byte_i;
        len = 2'd1;
      end
      2'd1: begin
        byte_buf[0] = pend_q[0];
        byte_buf[1] = byte_i;
        len = 2'd2;
      end
      default: begin
        byte_buf[0] = pend_q[0];
        byte_buf[1] = pend_q[1];
        byte_buf[2] = byte_i;
        len = 2'd3;
      end
    endcase
  end

  always_comb begin
    idx = '0;
    nres = '0;
    done = fin_q;
    stop = fin_q;
    uw = uw_q;
    bc = bc_q;
    inv = inv_q;
    items = '0;
    cur = '0;
    nx1 = '0;
    nx2 = '0;
    two = 1'b0;
    three = 1'b0;
    is_emit = 1'b0;
    is_fin = 1'b0;
    fin_st = 1'b0;
    unit = '0;
    used = '0;
    for (int s = 0; s < 3; s++) begin
      if (!done && !stop && idx < len) begin
        cur = byte_buf[idx];
        nx1 = byte_buf[idx + 2'd1];
        nx2 = byte_buf[idx + 2'd2];
        two = (cur & LEAD2_MASK) == LEAD2_TAG;
        three = (cur & LEAD3_MASK) == LEAD3_TAG;
        is_emit = 1'b0;
        is_fin = 1'b0;
        fin_st = 1'b0;
        unit = '0;
        used = '0;
        if (cap_hit(uw, cap_i)) begin
          is_fin = 1'b1;
        end else if (cur == 8'h00) begin
          is_fin = 1'b1;
        end else if (cur < ASCII_LIMIT) begin
          is_emit = 1'b1;
          unit = {8'h00, cur};
          used = 2'd1;
        end else if (two && (({1'b0, idx} + 3'd1) < {1'b0, len})) begin
          is_emit = 1'b1;
          unit = {5'b0, cur[4:0], nx1[5:0]};
          used = 2'd2;
        end else if (three && (({1'b0, idx} + 3'd2) < {1'b0, len})) begin
          is_emit = 1'b1;
          unit = {cur[3:0], nx1[5:0], nx2[5:0]};
          used = 2'd3;
        end else if ((two || three) && !eos_i) begin
          stop = 1'b1;
        end else begin
          inv = 1'b1;
          if (allow_i) begin
            is_emit = 1'b1;
            unit = REPLACE_UNIT;
            used = 2'd1;
          end else begin
            is_fin = 1'b1;
            fin_st = 1'b1;
          end
        end
        if (is_emit) begin
          if (nres != 2'd3) begin
            items[nres] = mk_res(unit, 1'b0, 1'b0, 1'b0, 16'h0000);
          end
          nres = nres + 2'd1;
          uw = uw + 16'd1;
          bc = sat_add(bc, used);
          idx = idx + used;
          if (cap_hit(uw, cap_i)) begin
            is_fin = 1'b1;
          end
        end
        if (is_fin) begin
          if (nres != 2'd3) begin
            items[nres] = mk_res(16'h0000, 1'b1, fin_st, inv, bc);
          end
          nres = nres + 2'd1;
          done = 1'b1;
        end
      end
    end
    // end of string closes an unfinished string
    if (!done && eos_i) begin
      if (nres != 2'd3) begin
        items[nres] = mk_res(16'h0000, 1'b1, 1'b0, inv, bc);
      end
      nres = nres + 2'd1;
      done = 1'b1;
    end
  end

  always_comb begin
    pend_d[0] = byte_buf[idx];
    pend_d[1] = byte_buf[idx + 2'd1];
    pcnt_d = '0;
    if (!done && !eos_i && idx < len) begin
      pcnt_d = len - idx;
    end
    uw_d = uw;
    bc_d = bc;
    inv_d = inv;
    fin_d = done;
    if (eos_i) begin
      pcnt_d = '0;
      uw_d = '0;
      bc_d = '0;
      inv_d = 1'b0;
      fin_d = 1'b0;
    end
  end

  assign batch_o.item = items;
  assign batch_o.count = nres;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= '0;
      uw_q <= '0;
      bc_q <= '0;
      fin_q <= 1'b0;
      inv_q <= 1'b0;
    end else if (fire_i) begin
      pcnt_q <= pcnt_d;
      uw_q <= uw_d;
      bc_q <= bc_d;
      fin_q <= fin_d;
      inv_q <= inv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      pend_q[0] <= pend_d[0];
      pend_q[1] <= pend_d[1];
    end
  end

endmodule

// ----- design/u8u16_res_buf.sv -----
module u8u16_res_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  u8u16_pkg::batch_t batch_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output u8u16_pkg::res_t   res_o,
  output logic              free_o
);
  import u8u16_pkg::*;

  res_t [2:0] items_q;
  logic [1:0] cnt_q;
  logic [1:0] rd_q;
  logic       pop;

  assign out_valid_o = cnt_q != 2'd0;
  assign pop = out_valid_o && !out_stall_i;
  assign free_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
  assign res_o = (rd_q == 2'd3) ? items_q[0] : items_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q <= '0;
    end else if (load_i) begin
      cnt_q <= batch_i.count;
      rd_q <= '0;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
      rd_q <= (cnt_q == 2'd1) ? 2'd0 : rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      items_q <= batch_i.item;
    end
  end

endmodule
